### hdl/ohm_pkg.sv
// ----------------------------------------------------------------------------
// ohm_pkg: shared definitions for the open-address hash map
// Field widths of the request and response transfers, operation codes and
// status codes.
// ----------------------------------------------------------------------------
package ohm_pkg;

  localparam int unsigned MODE_W = 2;
  localparam int unsigned KEY_W  = 64;
  localparam int unsigned VAL_W  = 64;
  localparam int unsigned LIVE_W = 6;

  typedef logic [MODE_W-1:0] mode_t;

  // Operation codes; the unused code behaves as a lookup.
  localparam mode_t MODE_LOOKUP = 2'd0;
  localparam mode_t MODE_INSERT = 2'd1;
  localparam mode_t MODE_DELETE = 2'd2;

  localparam logic STATUS_DONE = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

endpackage

### hdl/ohm_if.sv
// ----------------------------------------------------------------------------
// ohm_if: request and response channels of the hash map
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface ohm_req_if import ohm_pkg::*; ();
  logic              valid;
  logic              ready;
  mode_t             mode;
  logic [KEY_W-1:0]  key;
  logic [VAL_W-1:0]  value;

  modport source (output valid, output mode, output key, output value, input ready);
  modport sink   (input valid, input mode, input key, input value, output ready);
endinterface

interface ohm_rsp_if import ohm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              found;
  logic [VAL_W-1:0]  value_out;
  logic              status;
  logic [LIVE_W-1:0] live_count;

  modport source (output valid, output found, output value_out, output status,
                  output live_count, input ready);
  modport sink   (input valid, input found, input value_out, input status,
                  input live_count, output ready);
endinterface

### hdl/ohm_probe_step.sv
// ----------------------------------------------------------------------------
// ohm_probe_step: probe sequence step unit
// Shifts the perturbation right by five and forms the next slot index as
// five times the current index plus the new perturbation plus one.
// ----------------------------------------------------------------------------
module ohm_probe_step #(
  parameter int unsigned LOG_SLOTS = 6,
  parameter int unsigned KEY_BITS  = 64
) (
  input  logic [LOG_SLOTS-1:0] idx_i,
  input  logic [KEY_BITS-1:0]  perturb_i,
  output logic [LOG_SLOTS-1:0] idx_o,
  output logic [KEY_BITS-1:0]  perturb_o
);

  assign perturb_o = perturb_i >> 5;
  assign idx_o     = LOG_SLOTS'({idx_i, 2'b00}) + idx_i + LOG_SLOTS'(perturb_o)
                     + LOG_SLOTS'(1);

endmodule

### hdl/open_address_hash_map.sv
// ----------------------------------------------------------------------------
// open_address_hash_map: fixed-size open-addressing hash map
// Slot table of entry indices plus an insertion-ordered key/value entry
// array, with in-place compaction when the entry array runs out.
// ----------------------------------------------------------------------------
//
// Channel | Direction | Transfer contents
// --------+-----------+------------------------------------------------
// req_i   | in        | mode, key, value
// rsp_o   | out       | found, value_out, status, live_count
//
// Each probe step passes through a slot read and a slot check, plus an entry
// key compare when a find walk's slot holds an entry; every walk ends with a
// decision step. A lookup that hits then reads the value, and an insert of a
// new key runs a second walk for a free slot. The steps run one after another,
// as there is a single probe step unit and one read port on each memory.
// An insert that finds the entry array exhausted first compacts it when it
// holds deleted entries: one probe walk per used entry, a clearing sweep of
// all 2^LOG_SLOTS slots and one probe walk per surviving entry.
// After reset all 2^LOG_SLOTS slots of the table are swept to empty, and no
// request is taken during the sweep. One request is handled at a time; a new
// one is taken once the previous response has been transferred or is being
// transferred in the same cycle.
//
module open_address_hash_map
  import ohm_pkg::*;
#(
  parameter int unsigned LOG_SLOTS  = 6,
  parameter int unsigned KEY_BITS   = 64,
  parameter int unsigned VALUE_BITS = 64
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  ohm_req_if.sink   req_i,
  ohm_rsp_if.source rsp_o
);

  localparam int unsigned NSLOTS = 1 << LOG_SLOTS;
  localparam int unsigned USABLE = (NSLOTS * 2) / 3;
  localparam int unsigned EW     = $clog2(USABLE);
  localparam int unsigned CW     = $clog2(USABLE + 1);
  localparam int unsigned SW     = LOG_SLOTS + 1;
  localparam int unsigned LIMIT  = NSLOTS + 16;
  localparam int unsigned PCW    = LOG_SLOTS + 2;

  // Slot codes: entry indices are always below USABLE, so the two top codes
  // are free for the empty and deleted markers.
  localparam logic [SW-1:0] SLOT_EMPTY = {SW{1'b1}};
  localparam logic [SW-1:0] SLOT_DUMMY = {{(SW-1){1'b1}}, 1'b0};

  typedef enum logic [11:0] {
    S_CLR    = 12'b0000_0000_0001,
    S_IDLE   = 12'b0000_0000_0010,
    S_P_RD   = 12'b0000_0000_0100,
    S_P_SLOT = 12'b0000_0000_1000,
    S_P_KEY  = 12'b0000_0001_0000,
    S_AFTER  = 12'b0000_0010_0000,
    S_VRD    = 12'b0000_0100_0000,
    S_VOUT   = 12'b0000_1000_0000,
    S_CM_RD  = 12'b0001_0000_0000,
    S_CM_KEY = 12'b0010_0000_0000,
    S_MV_RD  = 12'b0100_0000_0000,
    S_MV_CHK = 12'b1000_0000_0000
  } state_e;

  // What a finished probe walk was for.
  typedef enum logic [1:0] {
    PH_OP_FIND = 2'd0,
    PH_OP_FREE = 2'd1,
    PH_CP_MARK = 2'd2,
    PH_CP_FREE = 2'd3
  } phase_e;

  state_e state_q, state_d;
  phase_e phase_q, phase_d;

  logic [LOG_SLOTS-1:0]  clr_q, clr_d;
  logic                  boot_q, boot_d;
  mode_t                 mode_q, mode_d;
  logic [KEY_BITS-1:0]   key_q, key_d;
  logic [VALUE_BITS-1:0] val_q, val_d;
  logic [KEY_BITS-1:0]   pkey_q, pkey_d;
  logic [KEY_BITS-1:0]   perturb_q, perturb_d;
  logic [LOG_SLOTS-1:0]  idx_q, idx_d;
  logic [PCW-1:0]        cnt_q, cnt_d;
  logic                  free_q, free_d;
  logic                  hit_q, hit_d;
  logic [EW-1:0]         hit_ix_q, hit_ix_d;
  logic [LOG_SLOTS-1:0]  pos_q, pos_d;
  logic [CW-1:0]         j_q, j_d;
  logic [CW-1:0]         k_q, k_d;
  logic [CW-1:0]         used_q, used_d;
  logic [CW-1:0]         live_q, live_d;

  logic                  ovalid_q, ovalid_d;
  logic                  found_q, found_d;
  logic [VALUE_BITS-1:0] vout_q, vout_d;
  logic                  status_q, status_d;
  logic [LIVE_W-1:0]     lc_q, lc_d;

  // Memories with registered reads.
  logic [SW-1:0]         slot_mem  [NSLOTS];
  logic [KEY_BITS-1:0]   key_mem   [USABLE];
  logic [VALUE_BITS-1:0] val_mem   [USABLE];
  logic                  alive_mem [USABLE];
  logic [SW-1:0]         slot_rd_q;
  logic [KEY_BITS-1:0]   key_rd_q;
  logic [VALUE_BITS-1:0] val_rd_q;
  logic                  alive_rd_q;

  logic                  slot_we;
  logic [LOG_SLOTS-1:0]  slot_wa;
  logic [SW-1:0]         slot_wd;
  logic                  key_we;
  logic [EW-1:0]         key_wa;
  logic [KEY_BITS-1:0]   key_wd;
  logic                  val_we;
  logic [EW-1:0]         val_wa;
  logic [VALUE_BITS-1:0] val_wd;
  logic                  alive_we;
  logic                  alive_wd;
  logic [EW-1:0]         key_ra;
  logic [EW-1:0]         val_ra;
  logic [EW-1:0]         j_ix;

  logic                  accept;
  logic                  adv;
  logic                  fin;
  logic                  walk_go;
  logic                  walk_free;
  phase_e                walk_phase;
  logic [KEY_BITS-1:0]   walk_key;
  logic [LOG_SLOTS-1:0]  step_idx;
  logic [KEY_BITS-1:0]   step_pert;
  logic [EW-1:0]         slot_ix;

  ohm_probe_step #(
    .LOG_SLOTS (LOG_SLOTS),
    .KEY_BITS  (KEY_BITS)
  ) u_step (
    .idx_i     (idx_q),
    .perturb_i (perturb_q),
    .idx_o     (step_idx),
    .perturb_o (step_pert)
  );

  assign req_i.ready = (state_q == S_IDLE) && (!ovalid_q || rsp_o.ready);
  assign accept      = req_i.valid && req_i.ready;

  assign rsp_o.valid      = ovalid_q;
  assign rsp_o.found      = found_q;
  assign rsp_o.value_out  = VAL_W'(vout_q);
  assign rsp_o.status     = status_q;
  assign rsp_o.live_count = lc_q;

  assign j_ix    = (j_q < CW'(USABLE)) ? j_q[EW-1:0] : '0;
  assign slot_ix = slot_rd_q[EW-1:0];
  assign key_ra  = (state_q == S_P_SLOT) ? slot_ix : j_ix;
  assign val_ra  = (state_q == S_VRD) ? hit_ix_q : j_ix;

  always_comb begin
    state_d   = state_q;
    phase_d   = phase_q;
    clr_d     = clr_q;
    boot_d    = boot_q;
    mode_d    = mode_q;
    key_d     = key_q;
    val_d     = val_q;
    pkey_d    = pkey_q;
    perturb_d = perturb_q;
    idx_d     = idx_q;
    cnt_d     = cnt_q;
    free_d    = free_q;
    hit_d     = hit_q;
    hit_ix_d  = hit_ix_q;
    pos_d     = pos_q;
    j_d       = j_q;
    k_d       = k_q;
    used_d    = used_q;
    live_d    = live_q;
    ovalid_d  = ovalid_q && !rsp_o.ready;
    found_d   = found_q;
    vout_d    = vout_q;
    status_d  = status_q;
    lc_d      = lc_q;

    slot_we    = 1'b0;
    slot_wa    = pos_q;
    slot_wd    = SLOT_DUMMY;
    key_we     = 1'b0;
    key_wa     = k_q[EW-1:0];
    key_wd     = key_rd_q;
    val_we     = 1'b0;
    val_wa     = k_q[EW-1:0];
    val_wd     = val_rd_q;
    alive_we   = 1'b0;
    alive_wd   = 1'b0;

    adv        = 1'b0;
    fin        = 1'b0;
    walk_go    = 1'b0;
    walk_free  = 1'b0;
    walk_phase = PH_OP_FIND;
    walk_key   = key_q;

    case (state_q)
      S_CLR: begin
        slot_we = 1'b1;
        slot_wa = clr_q;
        slot_wd = SLOT_EMPTY;
        clr_d   = clr_q + LOG_SLOTS'(1);
        if (clr_q == LOG_SLOTS'(NSLOTS - 1)) begin
          if (boot_q) begin
            state_d = S_IDLE;
          end else begin
            j_d     = '0;
            k_d     = '0;
            state_d = S_MV_RD;
          end
          boot_d = 1'b0;
        end
      end

      S_IDLE: begin
        if (accept) begin
          mode_d     = req_i.mode;
          key_d      = KEY_BITS'(req_i.key);
          val_d      = VALUE_BITS'(req_i.value);
          walk_go    = 1'b1;
          walk_key   = KEY_BITS'(req_i.key);
          walk_phase = PH_OP_FIND;
        end
      end

      S_P_RD: begin
        state_d = S_P_SLOT;
      end

      S_P_SLOT: begin
        if (free_q) begin
          if (slot_rd_q == SLOT_EMPTY || slot_rd_q == SLOT_DUMMY) begin
            hit_d   = 1'b1;
            pos_d   = idx_q;
            state_d = S_AFTER;
          end else begin
            adv = 1'b1;
          end
        end else if (slot_rd_q == SLOT_EMPTY) begin
          hit_d   = 1'b0;
          state_d = S_AFTER;
        end else if (slot_rd_q == SLOT_DUMMY) begin
          adv = 1'b1;
        end else begin
          state_d = S_P_KEY;
        end
      end

      S_P_KEY: begin
        if (key_rd_q == pkey_q) begin
          hit_d    = 1'b1;
          hit_ix_d = slot_ix;
          pos_d    = idx_q;
          state_d  = S_AFTER;
        end else begin
          adv = 1'b1;
        end
      end

      S_AFTER: begin
        case (phase_q)
          PH_OP_FIND: begin
            found_d  = hit_q;
            vout_d   = '0;
            status_d = STATUS_DONE;
            case (mode_q)
              MODE_INSERT: begin
                if (hit_q) begin
                  val_we = 1'b1;
                  val_wa = hit_ix_q;
                  val_wd = val_q;
                  fin    = 1'b1;
                end else if (used_q >= CW'(USABLE) && live_q < used_q) begin
                  j_d     = '0;
                  state_d = S_CM_RD;
                end else if (used_q < CW'(USABLE)) begin
                  walk_go    = 1'b1;
                  walk_free  = 1'b1;
                  walk_phase = PH_OP_FREE;
                end else begin
                  status_d = STATUS_FULL;
                  fin      = 1'b1;
                end
              end
              MODE_DELETE: begin
                if (hit_q) begin
                  slot_we = 1'b1;
                  slot_wa = pos_q;
                  slot_wd = SLOT_DUMMY;
                  if (live_q != '0) begin
                    live_d = live_q - CW'(1);
                  end
                end
                fin = 1'b1;
              end
              default: begin
                if (hit_q) begin
                  state_d = S_VRD;
                end else begin
                  fin = 1'b1;
                end
              end
            endcase
          end

          PH_OP_FREE: begin
            if (hit_q) begin
              slot_we = 1'b1;
              slot_wa = pos_q;
              slot_wd = SW'(used_q);
              key_we  = 1'b1;
              key_wa  = used_q[EW-1:0];
              key_wd  = key_q;
              val_we  = 1'b1;
              val_wa  = used_q[EW-1:0];
              val_wd  = val_q;
              used_d  = used_q + CW'(1);
              live_d  = live_q + CW'(1);
            end else begin
              status_d = STATUS_FULL;
            end
            fin = 1'b1;
          end

          PH_CP_MARK: begin
            alive_we = 1'b1;
            alive_wd = hit_q && (hit_ix_q == j_q[EW-1:0]);
            j_d      = j_q + CW'(1);
            if ((j_q + CW'(1)) < used_q) begin
              state_d = S_CM_RD;
            end else begin
              clr_d   = '0;
              boot_d  = 1'b0;
              state_d = S_CLR;
            end
          end

          default: begin
            if (hit_q) begin
              slot_we = 1'b1;
              slot_wa = pos_q;
              slot_wd = SW'(k_q);
            end
            k_d     = k_q + CW'(1);
            j_d     = j_q + CW'(1);
            state_d = S_MV_RD;
          end
        endcase
      end

      S_VRD: begin
        state_d = S_VOUT;
      end

      S_VOUT: begin
        vout_d = val_rd_q;
        fin    = 1'b1;
      end

      S_CM_RD: begin
        state_d = S_CM_KEY;
      end

      S_CM_KEY: begin
        walk_go    = 1'b1;
        walk_key   = key_rd_q;
        walk_phase = PH_CP_MARK;
      end

      S_MV_RD: begin
        state_d = S_MV_CHK;
      end

      S_MV_CHK: begin
        if (j_q >= used_q) begin
          used_d = k_q;
          live_d = k_q;
          if (k_q < CW'(USABLE)) begin
            walk_go    = 1'b1;
            walk_free  = 1'b1;
            walk_phase = PH_OP_FREE;
          end else begin
            status_d = STATUS_FULL;
            fin      = 1'b1;
          end
        end else if (!alive_rd_q) begin
          j_d     = j_q + CW'(1);
          state_d = S_MV_RD;
        end else begin
          key_we     = 1'b1;
          val_we     = 1'b1;
          walk_go    = 1'b1;
          walk_free  = 1'b1;
          walk_key   = key_rd_q;
          walk_phase = PH_CP_FREE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Probe walk: either give up at the step bound or take the next slot.
    if (adv) begin
      if (cnt_q == PCW'(LIMIT - 1)) begin
        hit_d   = 1'b0;
        state_d = S_AFTER;
      end else begin
        cnt_d     = cnt_q + PCW'(1);
        idx_d     = step_idx;
        perturb_d = step_pert;
        state_d   = S_P_RD;
      end
    end

    if (walk_go) begin
      pkey_d    = walk_key;
      perturb_d = walk_key;
      idx_d     = LOG_SLOTS'(walk_key);
      cnt_d     = '0;
      free_d    = walk_free;
      phase_d   = walk_phase;
      hit_d     = 1'b0;
      state_d   = S_P_RD;
    end

    if (fin) begin
      ovalid_d = 1'b1;
      lc_d     = LIVE_W'(live_d);
      state_d  = S_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLR;
      phase_q  <= PH_OP_FIND;
      clr_q    <= '0;
      boot_q   <= 1'b1;
      free_q   <= 1'b0;
      hit_q    <= 1'b0;
      cnt_q    <= '0;
      j_q      <= '0;
      k_q      <= '0;
      used_q   <= '0;
      live_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      phase_q  <= phase_d;
      clr_q    <= clr_d;
      boot_q   <= boot_d;
      free_q   <= free_d;
      hit_q    <= hit_d;
      cnt_q    <= cnt_d;
      j_q      <= j_d;
      k_q      <= k_d;
      used_q   <= used_d;
      live_q   <= live_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q    <= mode_d;
    key_q     <= key_d;
    val_q     <= val_d;
    pkey_q    <= pkey_d;
    perturb_q <= perturb_d;
    idx_q     <= idx_d;
    hit_ix_q  <= hit_ix_d;
    pos_q     <= pos_d;
    found_q   <= found_d;
    vout_q    <= vout_d;
    status_q  <= status_d;
    lc_q      <= lc_d;
  end

  // Memories: one write and one registered read each per cycle.
  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      slot_mem[slot_wa] <= slot_wd;
    end
    slot_rd_q <= slot_mem[idx_q];
  end

  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[key_wa] <= key_wd;
    end
    key_rd_q <= key_mem[key_ra];
  end

  always_ff @(posedge clk_i) begin
    if (val_we) begin
      val_mem[val_wa] <= val_wd;
    end
    val_rd_q <= val_mem[val_ra];
  end

  always_ff @(posedge clk_i) begin
    if (alive_we) begin
      alive_mem[j_ix] <= alive_wd;
    end
    alive_rd_q <= alive_mem[j_ix];
  end

  // The live count never exceeds the number of entries in use.
  a_live_le_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    live_q <= used_q)
    else $error("live count above used entries");

  // The entry array is never overrun.
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CW'(USABLE))
    else $error("used entries beyond the entry array");

  // A rejected insert never reports the key as present.
  a_full_not_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.status == STATUS_FULL) |-> !rsp_o.found)
    else $error("rejected insert reports a present key");

  // A request transfer always starts a probe walk on the next cycle.
  a_accept_probe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_P_RD && cnt_q == '0))
    else $error("request not followed by a probe walk");

  // A response only appears when an operation has just completed.
  a_rsp_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ovalid_q) |-> (state_q == S_IDLE))
    else $error("response raised outside operation completion");

endmodule

### sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the open-address hash map
// Drives lookups, inserts and deletes through the request channel and checks
// every response transfer against a behavioural copy of the map held here.
// ----------------------------------------------------------------------------
module testbench;
  import ohm_pkg::*;

  localparam int unsigned NSLOTS     = 64;
  localparam int unsigned USABLE     = (NSLOTS * 2) / 3;
  localparam int unsigned PROBE_MAX  = NSLOTS + 16;
  localparam int          SLOT_EMPTY = -1;
  localparam int          SLOT_DUMMY = -2;
  localparam int unsigned N_RANDOM   = 1000;
  localparam int unsigned CYCLE_CAP  = 400000;

  typedef struct packed {
    logic              found;
    logic [VAL_W-1:0]  value_out;
    logic              status;
    logic [LIVE_W-1:0] live_count;
  } map_rsp_t;

  // One row of the directed stimulus; has_rsp marks a response typed in here.
  typedef struct {
    mode_t            mode;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
    bit               has_rsp;
    map_rsp_t         rsp;
  } step_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  ohm_req_if req_if ();
  ohm_rsp_if rsp_if ();

  open_address_hash_map DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if.sink),
    .rsp_o  (rsp_if.source)
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the map state.
  int               slot_tab [NSLOTS];
  logic [KEY_W-1:0] ent_key  [USABLE];
  logic [VAL_W-1:0] ent_val  [USABLE];
  int               used_cnt;
  int               live_cnt;

  map_rsp_t pending_rsp[$];
  map_rsp_t typed_rsp[$];
  bit       typed_flag[$];
  int       err_cnt = 0;
  int       cycle_cnt = 0;
  int       stall_hold = 0;   // receiver hold-off, counted down in cycles
  bit       no_idle = 1'b0;   // stretch with no idling on either side
  logic [KEY_W-1:0] key_pool[$];

  task automatic report_mismatch(input string what, input logic [VAL_W-1:0] got,
                                 input logic [VAL_W-1:0] want);
    $display("MISMATCH at cycle %0d: %s got %0h expected %0h", cycle_cnt, what, got, want);
    err_cnt++;
  endtask

  function automatic int probe_next(input int i, inout logic [KEY_W-1:0] perturb);
    perturb = perturb >> 5;
    return int'((64'(i) * 5 + perturb + 1) & (NSLOTS - 1));
  endfunction

  // Entry index holding key, or -1; slot_at receives its slot.
  function automatic int locate_key(input logic [KEY_W-1:0] key, output int slot_at);
    logic [KEY_W-1:0] perturb;
    int i;
    int s;
    perturb = key;
    i = int'(key & (NSLOTS - 1));
    slot_at = 0;
    for (int n = 0; n < PROBE_MAX; n++) begin
      s = slot_tab[i];
      if (s == SLOT_EMPTY) return -1;
      if (s >= 0 && s < USABLE && ent_key[s] == key) begin
        slot_at = i;
        return s;
      end
      i = probe_next(i, perturb);
    end
    return -1;
  endfunction

  function automatic int free_slot_for(input logic [KEY_W-1:0] key);
    logic [KEY_W-1:0] perturb;
    int i;
    perturb = key;
    i = int'(key & (NSLOTS - 1));
    for (int n = 0; n < PROBE_MAX; n++) begin
      if (slot_tab[i] == SLOT_EMPTY || slot_tab[i] == SLOT_DUMMY) return i;
      i = probe_next(i, perturb);
    end
    return -1;
  endfunction

  // Moves reachable entries to the front in order and rebuilds the slots.
  function automatic void compact_entries();
    bit alive[USABLE];
    int k;
    int pos;
    k = 0;
    for (int j = 0; j < used_cnt; j++) alive[j] = (locate_key(ent_key[j], pos) == j);
    foreach (slot_tab[j]) slot_tab[j] = SLOT_EMPTY;
    for (int j = 0; j < used_cnt; j++) begin
      if (alive[j]) begin
        ent_key[k] = ent_key[j];
        ent_val[k] = ent_val[j];
        pos = free_slot_for(ent_key[k]);
        if (pos >= 0) slot_tab[pos] = k;
        k++;
      end
    end
    used_cnt = k;
    live_cnt = k;
  endfunction

  function automatic map_rsp_t apply_map_op(input mode_t mode, input logic [KEY_W-1:0] key,
                                            input logic [VAL_W-1:0] value);
    map_rsp_t r;
    int pos;
    int ix;
    int slot;
    ix = locate_key(key, pos);
    r = '0;
    r.found = (ix >= 0);
    r.status = STATUS_DONE;
    if (mode == MODE_INSERT) begin
      if (ix >= 0) begin
        ent_val[ix] = value;
      end else begin
        if (used_cnt >= USABLE && live_cnt < used_cnt) compact_entries();
        slot = (used_cnt < USABLE) ? free_slot_for(key) : -1;
        if (slot < 0) begin
          r.status = STATUS_FULL;
        end else begin
          slot_tab[slot] = used_cnt;
          ent_key[used_cnt] = key;
          ent_val[used_cnt] = value;
          used_cnt++;
          live_cnt++;
        end
      end
    end else if (mode == MODE_DELETE) begin
      if (ix >= 0) begin
        slot_tab[pos] = SLOT_DUMMY;
        if (live_cnt > 0) live_cnt--;
      end
    end else if (ix >= 0) begin
      r.value_out = ent_val[ix];
    end
    r.live_count = LIVE_W'(live_cnt);
    return r;
  endfunction

  function automatic step_row_t make_row(input mode_t m, input logic [KEY_W-1:0] k,
                                         input logic [VAL_W-1:0] v, input bit t = 0,
                                         input logic f = 0, input logic [VAL_W-1:0] vo = 0,
                                         input logic st = 0, input int lc = 0);
    step_row_t r;
    r.mode = m;
    r.key = k;
    r.value = v;
    r.has_rsp = t;
    r.rsp = '{found: f, value_out: vo, status: st, live_count: LIVE_W'(lc)};
    return r;
  endfunction

  // Offers one request, idling at random first, and records its expectation.
  // Valid stays high after the transfer so that requests can follow back to
  // back; the caller drops it before any pause.
  task automatic send_request(input step_row_t row);
    map_rsp_t want;
    while (!no_idle && $urandom_range(99) < 38) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.mode  <= row.mode;
    req_if.key   <= row.key;
    req_if.value <= row.value;
    do @(posedge clk_i); while (!req_if.ready);
    want = apply_map_op(row.mode, row.key, row.value);
    pending_rsp.push_back(want);
    typed_flag.push_back(row.has_rsp);
    typed_rsp.push_back(row.rsp);
    @(negedge clk_i);
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    // Mostly keys from a small pool sharing low bits, so probe chains collide.
    if (key_pool.size() != 0 && $urandom_range(99) < 60)
      return key_pool[$urandom_range(key_pool.size() - 1)];
    if ($urandom_range(3) == 0) return {$urandom, $urandom};
    return {$urandom, $urandom} & 64'hFFFF_FFFF_FFFF_F80F;
  endfunction

  // Receiver: random stalls plus one long hold-off.
  always @(negedge clk_i) begin
    if (stall_hold > 0) begin
      stall_hold <= stall_hold - 1;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 38);
    end
  end

  // Checks each response transfer against the oldest expectation.
  always @(posedge clk_i) begin
    map_rsp_t got;
    map_rsp_t want;
    bit typed;
    map_rsp_t typed_want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      got = '{rsp_if.found, rsp_if.value_out, rsp_if.status, rsp_if.live_count};
      if (pending_rsp.size() == 0) begin
        report_mismatch("unexpected response", got.value_out, '0);
      end else begin
        want = pending_rsp.pop_front();
        typed = typed_flag.pop_front();
        typed_want = typed_rsp.pop_front();
        // A typed-in response must agree with the predictor as well.
        if (typed && typed_want != want)
          report_mismatch("table row", typed_want.value_out, want.value_out);
        if (got.found != want.found)
          report_mismatch("found", VAL_W'(got.found), VAL_W'(want.found));
        if (got.value_out != want.value_out)
          report_mismatch("value_out", got.value_out, want.value_out);
        if (got.status != want.status)
          report_mismatch("status", VAL_W'(got.status), VAL_W'(want.status));
        if (got.live_count != want.live_count)
          report_mismatch("live_count", VAL_W'(got.live_count), VAL_W'(want.live_count));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_CAP) begin
      $display("timeout");
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    step_row_t directed[$];
    step_row_t row;
    int r;
    logic [KEY_W-1:0] k;
    req_if.valid = 1'b0;
    req_if.mode  = MODE_LOOKUP;
    req_if.key   = '0;
    req_if.value = '0;
    rsp_if.ready = 1'b0;
    foreach (slot_tab[j]) slot_tab[j] = SLOT_EMPTY;
    used_cnt = 0;
    live_cnt = 0;

    // Directed rows: extremes, every operation, unknown code, absent delete,
    // update in place and colliding keys that share the same home slot.
    directed.push_back(make_row(MODE_LOOKUP, '0, '1, 1, 0, 0, STATUS_DONE, 0));
    directed.push_back(make_row(MODE_DELETE, '1, '0, 1, 0, 0, STATUS_DONE, 0));
    directed.push_back(make_row(MODE_INSERT, '0, '1, 1, 0, 0, STATUS_DONE, 1));
    directed.push_back(make_row(MODE_INSERT, '1, '0, 1, 0, 0, STATUS_DONE, 2));
    directed.push_back(make_row(MODE_LOOKUP, '0, '0, 1, 1, '1, STATUS_DONE, 2));
    directed.push_back(make_row(2'd3, '1, '1, 1, 1, '0, STATUS_DONE, 2));
    directed.push_back(make_row(MODE_INSERT, '0, 64'h5555_AAAA_5555_AAAA, 1, 1, 0,
                                STATUS_DONE, 2));
    directed.push_back(make_row(MODE_LOOKUP, '0, '0));
    directed.push_back(make_row(MODE_INSERT, 64'h40, 64'h1));
    directed.push_back(make_row(MODE_INSERT, 64'h80, 64'h2));
    directed.push_back(make_row(MODE_INSERT, 64'h8000_0000_0000_0000, 64'h3));
    directed.push_back(make_row(MODE_DELETE, 64'h40, '0));
    directed.push_back(make_row(MODE_LOOKUP, 64'h80, '0));
    directed.push_back(make_row(MODE_INSERT, 64'h40, 64'h4));
    directed.push_back(make_row(MODE_DELETE, '0, '0, 1, 1, 0, STATUS_DONE, 4));
    directed.push_back(make_row(2'd3, '0, '0, 1, 0, 0, STATUS_DONE, 4));

    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed[j]) send_request(directed[j]);

    // Fill past the entry array with random churn so compaction and the full
    // status are reached repeatedly; the key pool keeps hits frequent.
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == 200) no_idle = 1'b1;
      if (n == 350) no_idle = 1'b0;
      if (n == 500) stall_hold <= 300;
      if (n == 700) begin
        req_if.valid <= 1'b0;
        wait (pending_rsp.size() == 0);
        @(negedge clk_i);
      end
      k = pick_key();
      if (key_pool.size() < 80 && $urandom_range(3) == 0) key_pool.push_back(k);
      r = $urandom_range(99);
      row = make_row(r < 45 ? MODE_INSERT : r < 70 ? MODE_DELETE :
                     r < 95 ? MODE_LOOKUP : mode_t'(2'd3),
                     k, {$urandom, $urandom});
      send_request(row);
    end

    req_if.valid <= 1'b0;
    wait (pending_rsp.size() == 0);
    repeat (50) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### open_address_hash_map.f
hdl/ohm_pkg.sv
hdl/ohm_if.sv
hdl/ohm_probe_step.sv
hdl/open_address_hash_map.sv
sim/testbench.sv
